[hdl/tia_pkg.sv]
// shared types and constants for the typed integer alu
package tia_pkg;

  localparam int unsigned DataWidthDefault = 64;

  typedef enum logic [3:0] {
    OP_MUL = 4'd0,
    OP_DIV = 4'd1,
    OP_MOD = 4'd2,
    OP_ADD = 4'd3,
    OP_SUB = 4'd4,
    OP_OR  = 4'd5,
    OP_AND = 4'd6,
    OP_XOR = 4'd7,
    OP_SHL = 4'd8,
    OP_ASR = 4'd9,
    OP_SHR = 4'd10,
    OP_NOT = 4'd11,
    OP_NEG = 4'd12,
    OP_POS = 4'd13
  } op_e;

  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_MUL  = 2'd1,
    KIND_DIV  = 2'd2,
    KIND_MOD  = 2'd3
  } kind_e;

  typedef struct packed {
    logic  valid;
    kind_e kind;
    logic  is_null;
    logic  neg_quo;
    logic  neg_rem;
  } ctrl_t;

endpackage

[hdl/tia_front.sv]
// operand decode, null check, simple operations and step unit setup
module tia_front #(
  parameter int unsigned DataWidth = tia_pkg::DataWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [3:0]           req_type_i,
  input  logic [63:0]          left_value_i,
  input  logic [63:0]          right_value_i,
  input  logic                 left_is_int_i,
  input  logic                 right_is_int_i,
  output tia_pkg::ctrl_t       ctrl_o,
  output logic [DataWidth-1:0] x_o,
  output logic [DataWidth-1:0] y_o,
  output logic [DataWidth-1:0] acc_o
);

  logic [DataWidth-1:0] a, b, ma, mb, shl_r, asr_r, shr_r, simple;
  logic                 neg_a, neg_b, big, unary, bad;
  tia_pkg::ctrl_t       ctrl_d, ctrl_q;
  logic [DataWidth-1:0] x_d, x_q, y_d, y_q, acc_d, acc_q;

  assign a     = left_value_i[DataWidth-1:0];
  assign b     = right_value_i[DataWidth-1:0];
  assign neg_a = a[DataWidth-1];
  assign neg_b = b[DataWidth-1];
  assign ma    = neg_a ? (~a + 1'b1) : a;
  assign mb    = neg_b ? (~b + 1'b1) : b;
  assign big   = (mb >= DataWidth'(DataWidth));
  assign shl_r = big ? '0 : (a << mb);
  assign asr_r = big ? '0 : DataWidth'($signed(a) >>> mb);
  assign shr_r = big ? '0 : (a >> mb);
  assign unary = (req_type_i >= tia_pkg::OP_NOT);

  always_comb begin
    case (req_type_i)
      tia_pkg::OP_ADD: simple = a + b;
      tia_pkg::OP_SUB: simple = a - b;
      tia_pkg::OP_OR:  simple = a | b;
      tia_pkg::OP_AND: simple = a & b;
      tia_pkg::OP_XOR: simple = a ^ b;
      tia_pkg::OP_SHL: simple = neg_b ? asr_r : shl_r;
      tia_pkg::OP_ASR: simple = neg_b ? shl_r : asr_r;
      tia_pkg::OP_SHR: simple = neg_b ? shl_r : shr_r;
      tia_pkg::OP_NOT: simple = ~a;
      tia_pkg::OP_NEG: simple = ~a + 1'b1;
      default:         simple = a;
    endcase
  end

  always_comb begin
    bad = !left_is_int_i || (!unary && !right_is_int_i) || (req_type_i > tia_pkg::OP_POS)
          || (((req_type_i == tia_pkg::OP_DIV) || (req_type_i == tia_pkg::OP_MOD))
              && (b == '0));
    ctrl_d.valid   = valid_i;
    ctrl_d.is_null = bad;
    ctrl_d.neg_quo = neg_a ^ neg_b;
    ctrl_d.neg_rem = neg_a;
    x_d   = a;
    y_d   = b;
    acc_d = '0;
    case (req_type_i)
      tia_pkg::OP_MUL: ctrl_d.kind = tia_pkg::KIND_MUL;
      tia_pkg::OP_DIV: begin
        ctrl_d.kind = tia_pkg::KIND_DIV;
        x_d = ma;
        y_d = mb;
      end
      tia_pkg::OP_MOD: begin
        ctrl_d.kind = tia_pkg::KIND_MOD;
        x_d = ma;
        y_d = mb;
      end
      default: begin
        ctrl_d.kind = tia_pkg::KIND_PASS;
        acc_d = simple;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      acc_q <= acc_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign acc_o  = acc_q;

endmodule

[hdl/tia_cell.sv]
// one shift-add multiply step, one restoring divide step, or a pass-through of the simple result
module tia_cell #(
  parameter int unsigned DataWidth = tia_pkg::DataWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  tia_pkg::ctrl_t       ctrl_i,
  input  logic [DataWidth-1:0] x_i,
  input  logic [DataWidth-1:0] y_i,
  input  logic [DataWidth-1:0] acc_i,
  output tia_pkg::ctrl_t       ctrl_o,
  output logic [DataWidth-1:0] x_o,
  output logic [DataWidth-1:0] y_o,
  output logic [DataWidth-1:0] acc_o
);

  tia_pkg::ctrl_t       ctrl_q;
  logic [DataWidth-1:0] x_d, x_q, y_d, y_q, acc_d, acc_q;
  logic [DataWidth-1:0] rem, diff, sum;
  logic                 ge;

  assign rem  = {acc_i[DataWidth-2:0], x_i[DataWidth-1]};
  assign ge   = (rem >= y_i);
  assign diff = rem - y_i;
  assign sum  = acc_i + x_i;

  always_comb begin
    x_d   = x_i;
    y_d   = y_i;
    acc_d = acc_i;
    case (ctrl_i.kind)
      tia_pkg::KIND_MUL: begin
        acc_d = y_i[0] ? sum : acc_i;
        x_d   = x_i << 1;
        y_d   = y_i >> 1;
      end
      tia_pkg::KIND_DIV, tia_pkg::KIND_MOD: begin
        acc_d = ge ? diff : rem;
        x_d   = {x_i[DataWidth-2:0], ge};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      acc_q <= acc_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign acc_o  = acc_q;

endmodule

[hdl/typed_int64_alu.sv]
// typed integer alu: front stage, chain of multiply/divide step cells, output register
// an input transfer passes through the front register, the DATA_WIDTH cell registers and the output register
// throughput: one transfer per cycle while the output is not stalled, set by the chain of DATA_WIDTH step cells
// a stalled output holds the whole chain; input is taken whenever the output moves
// reset: asynchronous active low, clears all valid flags, no result pending
module typed_int64_alu #(
  parameter int unsigned DATA_WIDTH = tia_pkg::DataWidthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  logic [127:0]  s_tdata_i,  // left_value, right_value
  input  logic [5:0]    s_tuser_i,  // req_type, left_is_int, right_is_int
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output logic [63:0]   m_tdata_o,  // result_value
  output logic          m_tuser_o   // result_null
);

  tia_pkg::ctrl_t        ctrl [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] xs   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] ys   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] accs [DATA_WIDTH+1];
  logic                  en, out_valid_q;
  logic [DATA_WIDTH-1:0] fin;
  logic [63:0]           data_d, data_q;
  logic                  null_d, null_q;
  tia_pkg::ctrl_t        last;

  assign en         = !out_valid_q || m_tready_i;
  assign s_tready_o = en;

  tia_front #(.DataWidth(DATA_WIDTH)) u_front (
    .clk_i,
    .rst_ni,
    .en_i          (en),
    .valid_i       (s_tvalid_i),
    .req_type_i    (s_tuser_i[3:0]),
    .left_value_i  (s_tdata_i[63:0]),
    .right_value_i (s_tdata_i[127:64]),
    .left_is_int_i (s_tuser_i[4]),
    .right_is_int_i(s_tuser_i[5]),
    .ctrl_o        (ctrl[0]),
    .x_o           (xs[0]),
    .y_o           (ys[0]),
    .acc_o         (accs[0])
  );

  for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
    tia_cell #(.DataWidth(DATA_WIDTH)) u_cell (
      .clk_i,
      .rst_ni,
      .en_i  (en),
      .ctrl_i(ctrl[g]),
      .x_i   (xs[g]),
      .y_i   (ys[g]),
      .acc_i (accs[g]),
      .ctrl_o(ctrl[g+1]),
      .x_o   (xs[g+1]),
      .y_o   (ys[g+1]),
      .acc_o (accs[g+1])
    );
  end

  assign last = ctrl[DATA_WIDTH];

  always_comb begin
    case (last.kind)
      tia_pkg::KIND_DIV: fin = last.neg_quo ? (~xs[DATA_WIDTH] + 1'b1) : xs[DATA_WIDTH];
      tia_pkg::KIND_MOD: fin = last.neg_rem ? (~accs[DATA_WIDTH] + 1'b1) : accs[DATA_WIDTH];
      default:           fin = accs[DATA_WIDTH];
    endcase
    null_d = last.is_null;
    data_d = last.is_null ? 64'd0
           : 64'($signed(fin));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
      null_q <= null_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = data_q;
  assign m_tuser_o  = null_q;

endmodule

[sim/typed_int64_alu_test.sv]
// testbench for the typed integer alu: queued stimulus, predicted results, random backpressure
module typed_int64_alu_test;

  localparam int unsigned DW = 64;
  localparam int unsigned LATENCY = DW + 2;

  typedef struct packed {
    logic [3:0]  op;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic        lhs_int;
    logic        rhs_int;
  } alu_req_t;

  typedef struct packed {
    logic [63:0] value;
    logic        is_null;
  } alu_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid_i = 1'b0;
  logic         s_tready_o;
  logic [127:0] s_tdata_i = '0;   // left_value, right_value
  logic [5:0]   s_tuser_i = '0;   // req_type, left_is_int, right_is_int
  logic         m_tvalid_o;
  logic         m_tready_i = 1'b0;
  logic [63:0]  m_tdata_o;        // result_value
  logic         m_tuser_o;        // result_null

  alu_req_t pending_reqs[$];
  alu_res_t expected_results[$];
  int       send_idle_pct = 26;
  int       recv_idle_pct = 59;
  bit       hold_send = 1'b0;
  bit       stim_done = 1'b0;
  int       mismatches = 0;
  int       results_seen = 0;
  int       reqs_sent = 0;

  typed_int64_alu #(.DATA_WIDTH(DW)) uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] shl_by(logic [63:0] a, logic [63:0] n);
    return (n >= 64) ? 64'd0 : a << n[5:0];
  endfunction

  function automatic logic [63:0] asr_by(logic [63:0] a, logic [63:0] n);
    return (n >= 64) ? 64'd0 : 64'($signed(a) >>> n[5:0]);
  endfunction

  function automatic logic [63:0] lsr_by(logic [63:0] a, logic [63:0] n);
    return (n >= 64) ? 64'd0 : a >> n[5:0];
  endfunction

  function automatic alu_res_t compute_result(alu_req_t q);
    alu_res_t    res;
    logic [63:0] a, b, mag, ma, t;
    bit          unary;
    a = q.lhs;
    b = q.rhs;
    unary = q.op >= tia_pkg::OP_NOT;
    mag = b[63] ? -b : b;
    ma = a[63] ? -a : a;
    res.is_null = 1'b0;
    res.value = '0;
    if (!q.lhs_int || (!unary && !q.rhs_int) || q.op > tia_pkg::OP_POS) begin
      res.is_null = 1'b1;
    end else begin
      case (q.op)
        tia_pkg::OP_MUL: res.value = a * b;
        tia_pkg::OP_DIV, tia_pkg::OP_MOD: begin
          if (b == 0) begin
            res.is_null = 1'b1;
          end else if (q.op == tia_pkg::OP_DIV) begin
            t = ma / mag;
            res.value = (a[63] != b[63]) ? -t : t;
          end else begin
            t = ma % mag;
            res.value = a[63] ? -t : t;
          end
        end
        tia_pkg::OP_ADD: res.value = a + b;
        tia_pkg::OP_SUB: res.value = a - b;
        tia_pkg::OP_OR:  res.value = a | b;
        tia_pkg::OP_AND: res.value = a & b;
        tia_pkg::OP_XOR: res.value = a ^ b;
        tia_pkg::OP_SHL: res.value = b[63] ? asr_by(a, mag) : shl_by(a, mag);
        tia_pkg::OP_ASR: res.value = b[63] ? shl_by(a, mag) : asr_by(a, mag);
        tia_pkg::OP_SHR: res.value = b[63] ? shl_by(a, mag) : lsr_by(a, mag);
        tia_pkg::OP_NOT: res.value = ~a;
        tia_pkg::OP_NEG: res.value = -a;
        default: res.value = a;
      endcase
    end
    if (res.is_null) res.value = '0;
    return res;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = 64'h8000_0000_0000_0000;
      1: v = 64'h7fff_ffff_ffff_ffff;
      2: v = '1;
      3: v = 64'($signed($urandom_range(0, 140)) - 70);
      4: v = 64'($signed({$urandom, $urandom}) >>> $urandom_range(0, 63));
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_req(logic [3:0] op, logic [63:0] a, logic [63:0] b, bit li, bit ri);
    alu_req_t q;
    q = '{op: op, lhs: a, rhs: b, lhs_int: li, rhs_int: ri};
    pending_reqs.push_back(q);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_tvalid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_tvalid_i || s_tready_o) begin
        if (pending_reqs.size() != 0 && !hold_send &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          alu_req_t q;
          q = pending_reqs.pop_front();
          s_tdata_i <= {q.rhs, q.lhs};
          s_tuser_i <= {q.rhs_int, q.lhs_int, q.op};
          s_tvalid_i <= 1'b1;
          expected_results.push_back(compute_result(q));
          reqs_sent++;
        end else begin
          s_tvalid_i <= 1'b0;
        end
      end
      m_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h null %b",
                                       m_tdata_o, m_tuser_o);
      end else begin
        alu_res_t e;
        e = expected_results.pop_front();
        if (m_tdata_o !== e.value || m_tuser_o !== e.is_null) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h null %b, got %h null %b",
                     e.value, e.is_null, m_tdata_o, m_tuser_o);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("timeout waiting for results");
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [63:0] mn, mx;
    int          k;
    logic [3:0]  op;
    mn = 64'h8000_0000_0000_0000;
    mx = 64'h7fff_ffff_ffff_ffff;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners
    queue_req(tia_pkg::OP_MUL, mx, mx, 1, 1);
    queue_req(tia_pkg::OP_DIV, mn, '1, 1, 1);
    queue_req(tia_pkg::OP_MOD, mn, '1, 1, 1);
    queue_req(tia_pkg::OP_DIV, 64'd7, 64'd0, 1, 1);
    queue_req(tia_pkg::OP_MOD, -64'sd7, 64'd2, 1, 1);
    queue_req(tia_pkg::OP_DIV, -64'sd7, 64'd2, 1, 1);
    queue_req(tia_pkg::OP_ADD, mx, 64'd1, 1, 1);
    queue_req(tia_pkg::OP_SUB, mn, 64'd1, 1, 1);
    queue_req(tia_pkg::OP_OR, mn, 64'h5, 1, 1);
    queue_req(tia_pkg::OP_AND, '1, mx, 1, 1);
    queue_req(tia_pkg::OP_XOR, '1, mn, 1, 1);
    queue_req(tia_pkg::OP_SHL, 64'h1, 64'd63, 1, 1);
    queue_req(tia_pkg::OP_SHL, mn, -64'sd4, 1, 1);
    queue_req(tia_pkg::OP_SHL, 64'h1, 64'd64, 1, 1);
    queue_req(tia_pkg::OP_ASR, mn, 64'd100, 1, 1);
    queue_req(tia_pkg::OP_ASR, mn, 64'd63, 1, 1);
    queue_req(tia_pkg::OP_ASR, 64'h3, -64'sd2, 1, 1);
    queue_req(tia_pkg::OP_SHR, '1, 64'd1, 1, 1);
    queue_req(tia_pkg::OP_SHR, 64'h3, mn, 1, 1);
    queue_req(tia_pkg::OP_NOT, 64'd0, '1, 1, 0);
    queue_req(tia_pkg::OP_NEG, mn, 64'd0, 1, 0);
    queue_req(tia_pkg::OP_POS, mx, 64'd0, 1, 0);
    queue_req(tia_pkg::OP_ADD, 64'd1, 64'd2, 0, 1);
    queue_req(tia_pkg::OP_ADD, 64'd1, 64'd2, 1, 0);
    queue_req(4'd14, 64'd1, 64'd2, 1, 1);
    queue_req(4'd15, 64'd1, 64'd2, 1, 1);

    for (k = 0; k < 700; k++) begin
      if (k == 233) begin
        send_idle_pct = 59;
        recv_idle_pct = 26;
      end
      if (k == 466) begin
        while (pending_reqs.size() != 0) @(posedge clk_i);
        hold_send = 1'b1;
        wait_drained();
        hold_send = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      op = ($urandom_range(0, 29) == 0) ? 4'($urandom_range(14, 15))
                                        : 4'($urandom_range(0, 13));
      queue_req(op, rand_operand(),
                (op >= tia_pkg::OP_SHL && op <= tia_pkg::OP_SHR && $urandom_range(0, 3) != 0)
                  ? 64'($signed($urandom_range(0, 140)) - 70) : rand_operand(),
                $urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0);
      while (pending_reqs.size() > 8) @(posedge clk_i);
    end

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("sent %0d requests over all opcodes, checked %0d results", reqs_sent,
             results_seen);
    $display("backpressure phases: sender-heavy, receiver-heavy, none; one full drain");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[typed_int64_alu.f]
hdl/tia_pkg.sv
hdl/tia_front.sv
hdl/tia_cell.sv
hdl/typed_int64_alu.sv
sim/typed_int64_alu_test.sv
